/* rtl/core/cwpm_pkg.sv */
// ----------------------------------------------------------------------------
// cwpm_pkg
// Shared types and constants of the circle wall mover.
// ----------------------------------------------------------------------------
package cwpm_pkg;

  localparam int unsigned WallSlots  = 16;
  localparam int unsigned WallIdxW   = 4;
  localparam int unsigned CoordW     = 24;
  localparam int unsigned SpanW      = 23;
  localparam int unsigned MaxPasses  = 8;
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned WallW      = 2 * CoordW + 2 * SpanW;

  localparam logic [1:0] OpWall = 2'd0;
  localparam logic [1:0] OpSet  = 2'd1;
  localparam logic [1:0] OpStep = 2'd2;

  localparam logic [CfgIdxW-1:0] RegWalls  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPasses = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSpeed  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRadius = 2'd3;

  // datapath commands from the controller
  typedef struct packed {
    logic load_pos;   // set position from input point
    logic load_tgt;   // latch target and step length
    logic move_start; // compute and apply move
    logic wall_start; // resolve current wall
    logic clr_hit;
  } cwpm_cmd_t;

  typedef struct packed {
    logic busy;
  } cwpm_sts_t;

endpackage

/* rtl/core/cwpm_ram.sv */
// ----------------------------------------------------------------------------
// cwpm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cwpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/cwpm_div.sv */
// ----------------------------------------------------------------------------
// cwpm_div
// Shared multi-cycle unit: restoring square root or division, one bit a cycle.
// ----------------------------------------------------------------------------
module cwpm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,   // 1: isqrt(num), 0: num / den
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] res_o
);
  import cwpm_pkg::*;

  logic [63:0] n_q, n_d, r_q, r_d, b_q, b_d, d_q, d_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d, sq_q, sq_d, done_q, done_d;
  logic [127:0] rem_q, rem_d;
  logic [64:0]  trial;

  always_comb begin
    n_d = n_q; r_d = r_q; b_d = b_q; d_d = d_q; cnt_d = cnt_q;
    run_d = run_q; sq_d = sq_q; done_d = 1'b0; rem_d = rem_q;
    trial = '0;
    if (start_i) begin
      run_d = 1'b1; sq_d = sqrt_i; n_d = num_i; d_d = den_i;
      r_d = '0; b_d = 64'h4000_0000_0000_0000; cnt_d = 7'd64;
      rem_d = {64'd0, num_i};
    end else if (run_q) begin
      if (sq_q) begin
        if (b_q == '0) begin
          run_d = 1'b0; done_d = 1'b1;
        end else if (n_q >= r_q + b_q) begin
          n_d = n_q - (r_q + b_q); r_d = (r_q >> 1) + b_q; b_d = b_q >> 2;
        end else begin
          r_d = r_q >> 1; b_d = b_q >> 2;
        end
      end else begin
        // shift-subtract divide, quotient in low half
        trial = {1'b0, rem_q[126:63]} - {1'b0, d_q};
        if (!trial[64]) begin
          rem_d = {trial[63:0], rem_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[126:0], 1'b0};
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_d = 1'b0; done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sq_q <= 1'b0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d; sq_q <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; b_q <= b_d; d_q <= d_d; rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = sq_q ? r_q : rem_q[63:0];
endmodule

/* rtl/core/cwpm_datapath.sv */
// ----------------------------------------------------------------------------
// cwpm_datapath
// Position registers, move and wall resolution sequenced over the shared unit.
// ----------------------------------------------------------------------------
module cwpm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cwpm_pkg::cwpm_cmd_t           cmd_i,
  output cwpm_pkg::cwpm_sts_t           sts_o,
  input  logic [cwpm_pkg::CoordW-1:0]   point_x_i,
  input  logic [cwpm_pkg::CoordW-1:0]   point_y_i,
  input  logic [15:0]                   delta_time_i,
  input  logic [23:0]                   speed_i,
  input  logic [15:0]                   radius_i,
  input  logic [cwpm_pkg::WallW-1:0]    wall_i,
  output logic [cwpm_pkg::CoordW-1:0]   pos_x_o,
  output logic [cwpm_pkg::CoordW-1:0]   pos_y_o,
  output logic                          hit_o
);
  import cwpm_pkg::*;

  typedef enum logic [6:0] {
    DIdle  = 7'b0000001,
    DSqrt  = 7'b0000010,
    DDivX  = 7'b0000100,
    DDivY  = 7'b0001000,
    DWait  = 7'b0010000,
    DTest  = 7'b0100000,
    DApply = 7'b1000000
  } dp_state_e;

  dp_state_e st_q, st_d;
  logic signed [CoordW-1:0] px_q, px_d, py_q, py_d;
  logic signed [CoordW+1:0] bx_q, bx_d, by_q, by_d;   // base point of update
  logic [25:0] ux_q, ux_d, uy_q, uy_d;                // magnitudes
  logic        nx_q, nx_d, ny_q, ny_d;
  logic [24:0] len_q, len_d;
  logic [63:0] den_q, den_d, qx_q, qx_d;
  logic        mv_q, mv_d, hit_q, hit_d;
  logic        dv_start, dv_sqrt, dv_done;
  logic [63:0] dv_num, dv_den, dv_res;

  // wall geometry (combinational from registered RAM data)
  logic signed [CoordW+1:0] wl, wt, wr, wb, cxp, cyp, cx, cy, ex, ey;
  logic [CoordW+1:0] aex, aey;
  logic [63:0] s;
  logic signed [CoordW+1:0] dl, dr, du, dd, best;
  logic [1:0] side;
  logic signed [CoordW+1:0] rad;
  logic [25:0] mx, my;
  logic [25:0] mmx, mmy;
  logic [64:0] pmove;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [CoordW+2:0] v);
    logic signed [CoordW+2:0] hi, lo;
    hi = (CoordW+3)'((1 << (CoordW-1)) - 1);
    lo = -hi - 1;
    if (v > hi) return hi[CoordW-1:0];
    if (v < lo) return lo[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

  always_comb begin
    wl = (CoordW+2)'($signed(wall_i[WallW-1 -: CoordW]));
    wt = (CoordW+2)'($signed(wall_i[WallW-CoordW-1 -: CoordW]));
    wr = wl + (CoordW+2)'(wall_i[2*SpanW-1 -: SpanW]);
    wb = wt + (CoordW+2)'(wall_i[SpanW-1:0]);
    cxp = (CoordW+2)'(px_q);
    cyp = (CoordW+2)'(py_q);
    cx = (cxp < wl) ? wl : ((cxp > wr) ? wr : cxp);
    cy = (cyp < wt) ? wt : ((cyp > wb) ? wb : cyp);
    ex = cxp - cx;
    ey = cyp - cy;
    aex = ex[CoordW+1] ? (CoordW+2)'(-ex) : ex;
    aey = ey[CoordW+1] ? (CoordW+2)'(-ey) : ey;
    s = 64'(aex) * 64'(aex) + 64'(aey) * 64'(aey);
    rad = (CoordW+2)'(radius_i);
    dl = cxp - wl; dr = wr - cxp; du = cyp - wt; dd = wb - cyp;
    best = dl; side = 2'd0;
    if (dr < best) begin best = dr; side = 2'd1; end
    if (du < best) begin best = du; side = 2'd2; end
    if (dd < best) begin best = dd; side = 2'd3; end
  end

  // direction magnitudes normalized below 2^25
  always_comb begin
    logic signed [CoordW+1:0] dx, dy;
    logic [CoordW+1:0] ax, ay;
    dx = (CoordW+2)'($signed(point_x_i)) - (CoordW+2)'(px_q);
    dy = (CoordW+2)'($signed(point_y_i)) - (CoordW+2)'(py_q);
    ax = dx[CoordW+1] ? (CoordW+2)'(-dx) : dx;
    ay = dy[CoordW+1] ? (CoordW+2)'(-dy) : dy;
    // 24-bit coords give |d| < 2^25 already
    mmx = ax[25:0];
    mmy = ay[25:0];
    mx = mmx;
    my = mmy;
  end

  always_comb begin
    st_d = st_q; px_d = px_q; py_d = py_q; bx_d = bx_q; by_d = by_q;
    ux_d = ux_q; uy_d = uy_q; nx_d = nx_q; ny_d = ny_q; len_d = len_q;
    den_d = den_q; qx_d = qx_q; mv_d = mv_q; hit_d = hit_q;
    dv_start = 1'b0; dv_sqrt = 1'b0; dv_num = '0; dv_den = den_q;
    pmove = '0;
    if (cmd_i.clr_hit) hit_d = 1'b0;
    if (cmd_i.load_pos) begin
      px_d = point_x_i; py_d = point_y_i;
    end
    case (st_q)
      DIdle: begin
        if (cmd_i.load_tgt) begin
          pmove = 65'(speed_i) * 65'(delta_time_i) + 65'd32768;
          len_d = pmove[40:16];
          ux_d = mx; uy_d = my;
          nx_d = ($signed(point_x_i) < px_q);
          ny_d = ($signed(point_y_i) < py_q);
        end
        if (cmd_i.move_start) begin
          if (ux_q == '0 && uy_q == '0) begin
            st_d = DWait;   // no move
          end else begin
            bx_d = (CoordW+2)'(px_q); by_d = (CoordW+2)'(py_q);
            mv_d = 1'b1;
            dv_start = 1'b1; dv_sqrt = 1'b1;
            dv_num = (64'(ux_q) * 64'(ux_q) + 64'(uy_q) * 64'(uy_q)) << 12;
            st_d = DSqrt;
          end
        end
        if (cmd_i.wall_start) st_d = DTest;
      end
      DTest: begin
        if (radius_i != '0 && aex < rad && aey < rad &&
            s < 64'(radius_i) * 64'(radius_i)) begin
          hit_d = 1'b1;
          if (s == '0) begin
            case (side)
              2'd0:    px_d = sat((CoordW+3)'(wl) - (CoordW+3)'(rad));
              2'd1:    px_d = sat((CoordW+3)'(wr) + (CoordW+3)'(rad));
              2'd2:    py_d = sat((CoordW+3)'(wt) - (CoordW+3)'(rad));
              default: py_d = sat((CoordW+3)'(wb) + (CoordW+3)'(rad));
            endcase
            st_d = DWait;
          end else begin
            bx_d = cx; by_d = cy; mv_d = 1'b0;
            ux_d = aex; uy_d = aey;
            nx_d = ex[CoordW+1]; ny_d = ey[CoordW+1];
            dv_start = 1'b1; dv_sqrt = 1'b1; dv_num = s << 12;
            st_d = DSqrt;
          end
        end else begin
          st_d = DWait;
        end
      end
      DSqrt: begin
        if (dv_done) begin
          den_d = dv_res;
          dv_start = 1'b1; dv_den = dv_res;
          dv_num = mv_q ? (64'(len_q) * 64'(ux_q)) << 6 : (64'(ux_q) * 64'(radius_i)) << 6;
          dv_num = dv_num + (dv_res >> 1);
          st_d = DDivX;
        end
      end
      DDivX: begin
        if (dv_done) begin
          qx_d = dv_res;
          dv_start = 1'b1;
          dv_num = mv_q ? (64'(len_q) * 64'(uy_q)) << 6 : (64'(uy_q) * 64'(radius_i)) << 6;
          dv_num = dv_num + (den_q >> 1);
          st_d = DDivY;
        end
      end
      DDivY: begin
        if (dv_done) begin
          px_d = sat(nx_q ? (CoordW+3)'(bx_q) - (CoordW+3)'(qx_q[25:0])
                          : (CoordW+3)'(bx_q) + (CoordW+3)'(qx_q[25:0]));
          py_d = sat(ny_q ? (CoordW+3)'(by_q) - (CoordW+3)'(dv_res[25:0])
                          : (CoordW+3)'(by_q) + (CoordW+3)'(dv_res[25:0]));
          st_d = DWait;
        end
      end
      DWait: st_d = DIdle;
      default: st_d = DIdle;
    endcase
  end

  cwpm_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .sqrt_i(dv_sqrt), .num_i(dv_num),
    .den_i(dv_den), .done_o(dv_done), .res_o(dv_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DIdle; px_q <= '0; py_q <= '0; hit_q <= 1'b0; mv_q <= 1'b0;
    end else begin
      st_q <= st_d; px_q <= px_d; py_q <= py_d; hit_q <= hit_d; mv_q <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q <= bx_d; by_q <= by_d; ux_q <= ux_d; uy_q <= uy_d;
    nx_q <= nx_d; ny_q <= ny_d; len_q <= len_d; den_q <= den_d; qx_q <= qx_d;
  end

  assign sts_o.busy = (st_q != DIdle);
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign hit_o = hit_q;
endmodule

/* rtl/core/cwpm_ctrl.sv */
// ----------------------------------------------------------------------------
// cwpm_ctrl
// Controller: decodes transactions, walks passes and walls, drives the output.
// ----------------------------------------------------------------------------
module cwpm_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [4:0]                   walls_i,
  input  logic [3:0]                   passes_i,
  output logic [cwpm_pkg::WallIdxW-1:0] rd_idx_o,
  output cwpm_pkg::cwpm_cmd_t          cmd_o,
  input  cwpm_pkg::cwpm_sts_t          sts_i
);
  import cwpm_pkg::*;

  typedef enum logic [6:0] {
    SIdle = 7'b0000001,
    SMove = 7'b0000010,
    SMvW  = 7'b0000100,
    SRd   = 7'b0001000,
    SWall = 7'b0010000,
    SWW   = 7'b0100000,
    SOut  = 7'b1000000
  } state_e;

  state_e st_q, st_d;
  logic [WallIdxW:0] w_q, w_d, nw_q, nw_d;
  logic [3:0] p_q, p_d, np_q, np_d;
  logic acc;

  assign in_stall_o = (st_q != SIdle);
  assign acc = in_valid_i && !in_stall_o;
  assign out_valid_o = (st_q == SOut);
  assign rd_idx_o = w_q[WallIdxW-1:0];

  always_comb begin
    st_d = st_q; w_d = w_q; p_d = p_q; nw_d = nw_q; np_d = np_q;
    cmd_o = '0;
    case (st_q)
      SIdle: begin
        if (acc && opcode_i == OpSet) begin
          cmd_o.load_pos = 1'b1; cmd_o.clr_hit = 1'b1; st_d = SOut;
        end else if (acc && opcode_i == OpStep) begin
          cmd_o.load_tgt = 1'b1; cmd_o.clr_hit = 1'b1;
          nw_d = (walls_i > 5'(WallSlots)) ? (WallIdxW+1)'(WallSlots) : walls_i;
          np_d = (passes_i > 4'(MaxPasses)) ? 4'(MaxPasses) : passes_i;
          st_d = SMove;
        end
      end
      SMove: begin
        cmd_o.move_start = 1'b1; st_d = SMvW;
      end
      SMvW: begin
        if (!sts_i.busy) begin
          w_d = '0; p_d = '0;
          st_d = (np_q == '0 || nw_q == '0) ? SOut : SRd;
        end
      end
      SRd: st_d = SWall;  // RAM read latency
      SWall: begin
        cmd_o.wall_start = 1'b1; st_d = SWW;
      end
      SWW: begin
        if (!sts_i.busy) begin
          if (w_q + 1'b1 == nw_q) begin
            w_d = '0;
            if (p_q + 4'd1 == np_q) st_d = SOut;
            else begin p_d = p_q + 4'd1; st_d = SRd; end
          end else begin
            w_d = w_q + 1'b1; st_d = SRd;
          end
        end
      end
      SOut: if (!out_stall_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; w_q <= '0; p_q <= '0; nw_q <= '0; np_q <= '0;
    end else begin
      st_q <= st_d; w_q <= w_d; p_q <= p_d; nw_q <= nw_d; np_q <= np_d;
    end
  end
endmodule

/* rtl/core/circle_wall_pushout_mover.sv */
// ----------------------------------------------------------------------------
// circle_wall_pushout_mover
// Moves a circle toward a target and pushes it out of a table of walls.
// ----------------------------------------------------------------------------
// One transaction at a time. A wall write gives no result; a set-position
// transaction presents its result on the cycle after it is taken. A step
// runs one square root and two 64-bit divides on a shared one-bit-per-cycle
// unit for the move, unless the target equals the position; it then visits
// up to 8 passes of 16 walls, and an overlapping wall whose nearest point is
// not the centre adds another square root and two divides.
module circle_wall_pushout_mover (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  wall_index_i,
  input  logic [23:0] wall_left_i,
  input  logic [23:0] wall_top_i,
  input  logic [22:0] wall_span_x_i,
  input  logic [22:0] wall_span_y_i,
  input  logic [23:0] point_x_i,
  input  logic [23:0] point_y_i,
  input  logic [15:0] delta_time_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] result_x_o,
  output logic [23:0] result_y_o,
  output logic        hit_any_wall_o,
  input  logic        cfg_we_i,
  input  logic [cwpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cwpm_pkg::CfgDataW-1:0] cfg_data_i
);
  import cwpm_pkg::*;

  logic [4:0]  walls_q;
  logic [3:0]  passes_q;
  logic [23:0] speed_q;
  logic [15:0] radius_q;
  cwpm_cmd_t   cmd;
  cwpm_sts_t   sts;
  logic [WallIdxW-1:0] rd_idx;
  logic [WallW-1:0]    wall_rd;
  logic                wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walls_q <= '0; passes_q <= 4'd5; speed_q <= '0; radius_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWalls:  walls_q  <= cfg_data_i[4:0];
        RegPasses: passes_q <= cfg_data_i[3:0];
        RegSpeed:  speed_q  <= cfg_data_i;
        RegRadius: radius_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign wr_en = in_valid && !in_stall && (opcode_i == OpWall);

  cwpm_ram #(.Width(WallW), .Depth(WallSlots)) u_walls (
    .clk_i, .we_i(wr_en), .waddr_i(wall_index_i),
    .wdata_i({wall_left_i, wall_top_i, wall_span_x_i, wall_span_y_i}),
    .raddr_i(rd_idx), .rdata_o(wall_rd)
  );

  cwpm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i, .out_valid_o(out_valid), .out_stall_i(out_stall),
    .walls_i(walls_q), .passes_i(passes_q), .rd_idx_o(rd_idx),
    .cmd_o(cmd), .sts_i(sts)
  );

  cwpm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .point_x_i, .point_y_i,
    .delta_time_i, .speed_i(speed_q), .radius_i(radius_q), .wall_i(wall_rd),
    .pos_x_o(result_x_o), .pos_y_o(result_y_o), .hit_o(hit_any_wall_o)
  );
endmodule

/* rtl/core/cwpm_checker.sv */
// ----------------------------------------------------------------------------
// cwpm_checker
// Port-level checks of the mover, bound to the top level.
// ----------------------------------------------------------------------------
module cwpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] result_x_o,
  input logic        hit_any_wall_o
);
  // one transaction at a time: no input accepted while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input accepted with result pending");
  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(result_x_o) && $stable(hit_any_wall_o))
    else $error("result changed while stalled");
  // result dropped after it is taken
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_stall |=> !out_valid) else $error("result repeated");
endmodule

bind circle_wall_pushout_mover cwpm_checker u_cwpm_checker (.*);
